/* hw/rtl/oaht_pkg.sv */
package oaht_pkg;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_GET    = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_ADDED    = 2'd0,
      ST_PRESENT  = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_EMPTY  = 2'd0,
      KIND_FILLED = 2'd1,
      KIND_TOMB   = 2'd2,
      KIND_SPARE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_CHECK,
      S_VALUE,
      S_OUT
   } state_type;

   typedef struct packed {
      action_type  action;
      logic [31:0] key;
      logic [31:0] hash;
      logic [31:0] value;
      logic        overwrite;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] value_out;
   } rsp_type;

endpackage

/* hw/rtl/open_address_hash_table.sv */
// Open-addressing key/value table. Each request (insert, get or delete) walks the probe
// sequence slot by slot through a single-port slot memory holding kind, key and hash,
// with values in a second memory read once the slot is settled. A request probes from
// one to PROBE_LIMIT slots. After reset a clearing pass marks every slot empty; no
// request is taken meanwhile. One request is in flight at a time; the result sits in an
// output register while the next request is taken, unless that result is stalled.
module open_address_hash_table #(
   parameter int TABLE_SLOTS   = 1024,
   parameter int PERTURB_SHIFT = 5,
   parameter int PROBE_LIMIT   = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  oaht_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output oaht_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [10:0]      csr_data
);

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int PW = $clog2(PROBE_LIMIT + 1);
   localparam int EW = 2 + 32 + 32;

   logic [EW-1:0] slot_mem [TABLE_SLOTS];
   logic [31:0]   val_mem  [TABLE_SLOTS];

   oaht_pkg::state_type state_ff, state_in;
   oaht_pkg::req_type   req_ff, req_in;
   oaht_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rspv_ff, rspv_in;
   logic [10:0]         maxf_ff, maxf_in;
   logic [10:0]         fill_ff, fill_in;
   logic [31:0]         idx_ff, idx_in;
   logic [31:0]         pert_ff, pert_in;
   logic [PW-1:0]       cnt_ff, cnt_in;
   logic                tomb_ff, tomb_in;
   logic [AW-1:0]       tslot_ff, tslot_in;
   logic [AW-1:0]       slot_ff, slot_in;
   logic                found_ff, found_in;
   logic [AW-1:0]       clr_ff, clr_in;

   logic [EW-1:0]       srd_ff;
   logic [31:0]         vrd_ff;
   logic                swe, vwe;
   logic [AW-1:0]       saddr, vaddr;
   logic [EW-1:0]       swdata;
   logic [31:0]         vwdata;

   oaht_pkg::kind_type  rkind;
   logic [31:0]         rkey, rhash;
   logic                accept;

   assign rkind = oaht_pkg::kind_type'(srd_ff[EW-1 -: 2]);
   assign rkey  = srd_ff[63:32];
   assign rhash = srd_ff[31:0];

   assign req_stall = (state_ff != oaht_pkg::S_IDLE) || (rspv_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (swe) begin
         slot_mem[saddr] <= swdata;
      end
      srd_ff <= slot_mem[saddr];
   end

   always_ff @(posedge clock) begin
      if (vwe) begin
         val_mem[vaddr] <= vwdata;
      end
      vrd_ff <= val_mem[vaddr];
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      rspv_in  = rspv_ff && rsp_stall;
      maxf_in  = csr_valid ? csr_data : maxf_ff;
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      pert_in  = pert_ff;
      cnt_in   = cnt_ff;
      tomb_in  = tomb_ff;
      tslot_in = tslot_ff;
      slot_in  = slot_ff;
      found_in = found_ff;
      clr_in   = clr_ff;
      swe      = 1'b0;
      vwe      = 1'b0;
      saddr    = idx_ff[AW-1:0];
      vaddr    = slot_ff;
      swdata   = {oaht_pkg::KIND_FILLED, req_ff.key, req_ff.hash};
      vwdata   = req_ff.value;
      case (state_ff)
         oaht_pkg::S_CLEAR: begin
            swe    = 1'b1;
            saddr  = clr_ff;
            swdata = {oaht_pkg::KIND_EMPTY, 64'd0};
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(TABLE_SLOTS - 1)) begin
               state_in = oaht_pkg::S_IDLE;
            end
         end
         oaht_pkg::S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               idx_in   = req_data.hash;
               pert_in  = req_data.hash;
               cnt_in   = '0;
               tomb_in  = 1'b0;
               found_in = 1'b0;
               if (req_data.action == oaht_pkg::ACT_NONE) begin
                  rsp_in   = '{oaht_pkg::ST_NOTFOUND, 32'd0};
                  rspv_in  = 1'b1;
               end else begin
                  state_in = oaht_pkg::S_READ;
               end
            end
         end
         oaht_pkg::S_READ: begin
            state_in = oaht_pkg::S_CHECK;
         end
         oaht_pkg::S_CHECK: begin
            slot_in  = idx_ff[AW-1:0];
            idx_in   = (idx_ff << 2) + idx_ff + pert_ff + 32'd1;
            pert_in  = pert_ff >> PERTURB_SHIFT;
            cnt_in   = cnt_ff + 1'b1;
            state_in = oaht_pkg::S_VALUE;
            if (rkind == oaht_pkg::KIND_FILLED) begin
               if (rhash == req_ff.hash && rkey == req_ff.key) begin
                  found_in = 1'b1;
               end else if (cnt_ff == PW'(PROBE_LIMIT - 1)) begin
                  slot_in = '0;
               end else begin
                  state_in = oaht_pkg::S_READ;
               end
            end else if (rkind == oaht_pkg::KIND_EMPTY) begin
               cnt_in = cnt_ff;
               if (tomb_ff) begin
                  slot_in = tslot_ff;
               end
            end else begin
               if (!tomb_ff) begin
                  tomb_in  = 1'b1;
                  tslot_in = idx_ff[AW-1:0];
               end
               if (cnt_ff == PW'(PROBE_LIMIT - 1)) begin
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  state_in = oaht_pkg::S_READ;
               end
            end
            if (state_in == oaht_pkg::S_VALUE && !found_in
                && rkind != oaht_pkg::KIND_EMPTY) begin
               cnt_in = PW'(PROBE_LIMIT);
            end
            saddr = idx_in[AW-1:0];
         end
         oaht_pkg::S_VALUE: begin
            state_in = oaht_pkg::S_OUT;
         end
         oaht_pkg::S_OUT: begin
            state_in = oaht_pkg::S_IDLE;
            rspv_in  = 1'b1;
            rsp_in   = '{oaht_pkg::ST_NOTFOUND, 32'd0};
            saddr    = slot_ff;
            if (found_ff) begin
               rsp_in = '{oaht_pkg::ST_PRESENT, vrd_ff};
               if (req_ff.action == oaht_pkg::ACT_INSERT) begin
                  vwe = req_ff.overwrite;
               end else if (req_ff.action == oaht_pkg::ACT_DELETE) begin
                  vwe    = 1'b1;
                  vwdata = 32'd0;
                  swe    = 1'b1;
                  swdata = {oaht_pkg::KIND_TOMB, rkey, rhash};
                  if (fill_ff != 11'd0) begin
                     fill_in = fill_ff - 1'b1;
                  end
               end
            end else if (req_ff.action == oaht_pkg::ACT_INSERT) begin
               if (cnt_ff == PW'(PROBE_LIMIT) || {1'b0, fill_ff} + 12'd1 > {1'b0, maxf_ff}) begin
                  rsp_in = '{oaht_pkg::ST_FULL, 32'd0};
               end else begin
                  rsp_in  = '{oaht_pkg::ST_ADDED, 32'd0};
                  swe     = 1'b1;
                  vwe     = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = oaht_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oaht_pkg::S_CLEAR;
         rspv_ff  <= 1'b0;
         maxf_ff  <= 11'd768;
         fill_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rspv_ff  <= rspv_in;
         maxf_ff  <= maxf_in;
         fill_ff  <= fill_in;
         clr_ff   <= clr_in;
      end
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      idx_ff   <= idx_in;
      pert_ff  <= pert_in;
      cnt_ff   <= cnt_in;
      tomb_ff  <= tomb_in;
      tslot_ff <= tslot_in;
      slot_ff  <= slot_in;
      found_ff <= found_in;
   end

   a_fill_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == oaht_pkg::S_OUT && fill_in != fill_ff && fill_in > fill_ff)
      |-> fill_in <= maxf_ff)
      else $error("fill count above limit");

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == oaht_pkg::S_CLEAR |-> req_stall)
      else $error("request taken during clearing pass");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rspv_ff && rsp_stall |=> rspv_ff && $stable(rsp_ff))
      else $error("stalled result lost");

endmodule

/* tb/open_address_hash_table_tb.sv */
module open_address_hash_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 1024;
   localparam int SHIFT = 5;
   localparam int LIMIT = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   oaht_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   oaht_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [10:0] csr_data = '0;

   open_address_hash_table u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   oaht_pkg::kind_type slot_kind [SLOTS];
   logic [31:0] slot_key  [SLOTS];
   logic [31:0] slot_hash [SLOTS];
   logic [31:0] slot_value[SLOTS];
   int unsigned fill_count;
   logic [10:0] max_fill;

   oaht_pkg::rsp_type expected_rsps[$];
   bit failed = 1'b0;
   int send_idle = 0;
   int recv_stall = 0;

   // key pool kept small so that hits, collisions and tombstones are common
   logic [31:0] pool_key[16];
   logic [31:0] pool_hash[16];

   function automatic oaht_pkg::rsp_type table_lookup(oaht_pkg::req_type r);
      oaht_pkg::rsp_type o;
      logic [31:0] idx, pert;
      int unsigned s, tomb;
      bit have_tomb, found, have_place;
      o.status = oaht_pkg::ST_NOTFOUND;
      o.value_out = '0;
      idx = r.hash & (SLOTS - 1);
      pert = r.hash;
      have_tomb = 0; found = 0; have_place = 0; tomb = 0; s = 0;
      if (r.action == oaht_pkg::ACT_NONE) return o;
      for (int p = 0; p < LIMIT; p++) begin
         s = idx & (SLOTS - 1);
         if (slot_kind[s] == oaht_pkg::KIND_FILLED) begin
            if (slot_hash[s] == r.hash && slot_key[s] == r.key) begin
               found = 1;
               break;
            end
         end else if (slot_kind[s] == oaht_pkg::KIND_TOMB) begin
            if (!have_tomb) begin
               have_tomb = 1;
               tomb = s;
            end
         end else begin
            have_place = 1;
            if (have_tomb) s = tomb;
            break;
         end
         idx = (idx << 2) + idx + pert + 1;
         pert = pert >> SHIFT;
      end
      if (r.action == oaht_pkg::ACT_INSERT) begin
         if (found) begin
            o.status = oaht_pkg::ST_PRESENT;
            o.value_out = slot_value[s];
            if (r.overwrite) slot_value[s] = r.value;
         end else if (!have_place || fill_count + 1 > max_fill) begin
            o.status = oaht_pkg::ST_FULL;
         end else begin
            slot_kind[s] = oaht_pkg::KIND_FILLED;
            slot_key[s] = r.key;
            slot_hash[s] = r.hash;
            slot_value[s] = r.value;
            fill_count++;
            o.status = oaht_pkg::ST_ADDED;
         end
      end else if (found) begin
         o.status = oaht_pkg::ST_PRESENT;
         o.value_out = slot_value[s];
         if (r.action == oaht_pkg::ACT_DELETE) begin
            slot_kind[s] = oaht_pkg::KIND_TOMB;
            slot_value[s] = '0;
            if (fill_count > 0) fill_count--;
         end
      end
      return o;
   endfunction

   task automatic send_item(oaht_pkg::req_type r);
      oaht_pkg::rsp_type e;
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = table_lookup(r);
      expected_rsps.push_back(e);
   endtask

   task automatic send_checked(oaht_pkg::req_type r, oaht_pkg::status_type st,
                               logic [31:0] v);
      oaht_pkg::rsp_type e;
      e.status = st;
      e.value_out = v;
      send_item(r);
      if (expected_rsps[$] !== e) begin
         $display("%0t typed-in mismatch: expected %p actual prediction %p",
            $time, e, expected_rsps[$]);
         failed = 1'b1;
      end
   endtask

   task automatic drain_and_write(logic [10:0] v);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      max_fill = v;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t unexpected item: actual %p", $time, rsp_data);
               failed = 1'b1;
            end else begin
               oaht_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_data.status !== e.status)
                  $display("%0t status mismatch: expected %s actual %s",
                     $time, e.status.name(), rsp_data.status.name());
               if (rsp_data.value_out !== e.value_out)
                  $display("%0t value mismatch: expected %h actual %h",
                     $time, e.value_out, rsp_data.value_out);
               if (rsp_data !== e) failed = 1'b1;
            end
         end
         rsp_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
      end
   end

   function automatic oaht_pkg::req_type mk(oaht_pkg::action_type a, logic [31:0] k,
                                            logic [31:0] h, logic [31:0] v, logic o);
      oaht_pkg::req_type r;
      r.action = a; r.key = k; r.hash = h; r.value = v; r.overwrite = o;
      return r;
   endfunction

   function automatic oaht_pkg::req_type random_req();
      oaht_pkg::req_type r;
      int p;
      p = $urandom_range(15);
      r.key = pool_key[p];
      r.hash = pool_hash[p];
      if ($urandom_range(9) == 0) begin
         r.key = $urandom;
         r.hash = $urandom;
      end
      r.value = ($urandom_range(9) == 0) ? '0 : $urandom;
      r.overwrite = $urandom_range(1);
      case ($urandom_range(19))
         0: r.action = oaht_pkg::ACT_NONE;
         1, 2, 3, 4, 5, 6, 7, 8: r.action = oaht_pkg::ACT_INSERT;
         9, 10, 11, 12, 13: r.action = oaht_pkg::ACT_GET;
         default: r.action = oaht_pkg::ACT_DELETE;
      endcase
      return r;
   endfunction

   typedef struct {
      oaht_pkg::req_type    r;
      bit                   typed;
      oaht_pkg::status_type st;
      logic [31:0]          v;
   } stim_row;

   initial begin
      stim_row rows[$];
      logic [10:0] fills[5];
      foreach (slot_kind[i]) begin
         slot_kind[i] = oaht_pkg::KIND_EMPTY;
         slot_key[i] = '0; slot_hash[i] = '0; slot_value[i] = '0;
      end
      fill_count = 0;
      max_fill = 11'd768;
      foreach (pool_key[i]) begin
         pool_key[i] = $urandom;
         pool_hash[i] = (i < 8) ? ($urandom & 32'hffff_ff07) : $urandom;
      end
      pool_hash[1] = pool_hash[0];

      rows.push_back('{mk(oaht_pkg::ACT_GET, 32'h0, 32'h0, 32'h0, 1'b0), 1,
         oaht_pkg::ST_NOTFOUND, 32'h0});
      rows.push_back('{mk(oaht_pkg::ACT_DELETE, 32'hffffffff, 32'hffffffff, 32'h0, 1'b0), 1,
         oaht_pkg::ST_NOTFOUND, 32'h0});
      rows.push_back('{mk(oaht_pkg::ACT_INSERT, 32'h0, 32'h0, 32'hffffffff, 1'b0), 1,
         oaht_pkg::ST_ADDED, 32'h0});
      rows.push_back('{mk(oaht_pkg::ACT_INSERT, 32'h0, 32'h0, 32'h1, 1'b0), 1,
         oaht_pkg::ST_PRESENT, 32'hffffffff});
      rows.push_back('{mk(oaht_pkg::ACT_INSERT, 32'h0, 32'h0, 32'h5, 1'b1), 1,
         oaht_pkg::ST_PRESENT, 32'hffffffff});
      rows.push_back('{mk(oaht_pkg::ACT_GET, 32'h0, 32'h0, 32'h0, 1'b0), 1,
         oaht_pkg::ST_PRESENT, 32'h5});
      rows.push_back('{mk(oaht_pkg::ACT_INSERT, 32'hffffffff, 32'hffffffff, 32'h0, 1'b1), 1,
         oaht_pkg::ST_ADDED, 32'h0});
      rows.push_back('{mk(oaht_pkg::ACT_GET, 32'hffffffff, 32'hffffffff, 32'h0, 1'b0), 1,
         oaht_pkg::ST_PRESENT, 32'h0});
      rows.push_back('{mk(oaht_pkg::ACT_INSERT, 32'h1, 32'h0, 32'h7, 1'b0), 0,
         oaht_pkg::ST_ADDED, 32'h0});
      rows.push_back('{mk(oaht_pkg::ACT_INSERT, 32'h0, 32'h400, 32'h8, 1'b0), 0,
         oaht_pkg::ST_ADDED, 32'h0});
      rows.push_back('{mk(oaht_pkg::ACT_DELETE, 32'h0, 32'h0, 32'h0, 1'b0), 1,
         oaht_pkg::ST_PRESENT, 32'h5});
      rows.push_back('{mk(oaht_pkg::ACT_GET, 32'h1, 32'h0, 32'h0, 1'b0), 0,
         oaht_pkg::ST_ADDED, 32'h0});
      rows.push_back('{mk(oaht_pkg::ACT_INSERT, 32'h2, 32'h0, 32'h9, 1'b0), 0,
         oaht_pkg::ST_ADDED, 32'h0});
      rows.push_back('{mk(oaht_pkg::ACT_NONE, 32'h1, 32'h0, 32'h0, 1'b1), 1,
         oaht_pkg::ST_NOTFOUND, 32'h0});
      rows.push_back('{mk(oaht_pkg::ACT_GET, 32'h0, 32'h0, 32'h0, 1'b0), 1,
         oaht_pkg::ST_NOTFOUND, 32'h0});
      rows.push_back('{mk(oaht_pkg::ACT_DELETE, 32'h1, 32'h0, 32'h0, 1'b0), 0,
         oaht_pkg::ST_ADDED, 32'h0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].typed) send_checked(rows[i].r, rows[i].st, rows[i].v);
         else send_item(rows[i].r);
      end

      // max fill at zero refuses every new key, then a small limit
      drain_and_write(11'd0);
      send_checked(mk(oaht_pkg::ACT_INSERT, 32'h1234, 32'h77, 32'h1, 1'b0),
         oaht_pkg::ST_FULL, 32'h0);
      drain_and_write(11'd6);
      for (int i = 0; i < 10; i++)
         send_item(mk(oaht_pkg::ACT_INSERT, $urandom, $urandom, $urandom, 1'b0));

      fills[0] = 11'd2047; fills[1] = 11'd12; fills[2] = 11'd1024;
      fills[3] = 11'd1; fills[4] = 11'd768;
      for (int ph = 0; ph < 5; ph++) begin
         drain_and_write(fills[ph]);
         case (ph)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 67; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 67; end
            3: begin send_idle = 29; recv_stall = 29; end
            default: begin send_idle = 0; recv_stall = 0; end
         endcase
         for (int n = 0; n < 160; n++) send_item(random_req());
      end

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end
endmodule
